// ===== hw/rtl/u16550rb_pkg.sv =====
// Package for the 16550-style register bridge: payload structs, codes, constants.
// Used by u16550rb_div and uart_16550_register_bridge_top.
package u16550rb_pkg;

   localparam int unsigned BaudWidth   = 24;
   localparam int unsigned CsrWidth    = 24;
   localparam int unsigned DivWidth    = 16;
   localparam int unsigned RefWidth    = 17;

   localparam logic [RefWidth-1:0]  CLOCK_REF    = 17'd115200;
   localparam logic [BaudWidth-1:0] BAUD_RESET   = 24'd115200;
   localparam logic [4:0]           DATA_RESET   = 5'd8;
   localparam logic [15:0]          BREAK_MIN_MS = 16'd250;
   localparam logic [DivWidth-1:0]  DIV_SAT      = 16'hFFFF;
   localparam logic [DivWidth-1:0]  DIV_RESET    = DivWidth'(115200 / 115200);

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_LINE  = 2'd2,
      KIND_BREAK = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_BAUD   = 2'd0,
      CSR_DATA   = 2'd1,
      CSR_STOP   = 2'd2,
      CSR_PARITY = 2'd3
   } csr_index_type;

   localparam logic [2:0] OFS_DATA = 3'd0;
   localparam logic [2:0] OFS_DLM  = 3'd1;
   localparam logic [2:0] OFS_LCR  = 3'd3;
   localparam logic [2:0] OFS_LSR  = 3'd5;
   localparam logic [2:0] OFS_MSR  = 3'd6;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  reg_offset;
      logic [7:0]  write_data;
      logic        rx_pending;
      logic [7:0]  rx_head;
      logic        tx_room;
      logic        host_ready;
      logic        dtr_level;
      logic        rts_level;
      logic [15:0] break_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       rx_consume;
      logic       tx_valid;
      logic [7:0] tx_byte;
   } rsp_type;

   typedef struct packed {
      logic                busy;
      logic [DivWidth-1:0] value;
   } div_status_type;

endpackage

// ===== hw/rtl/u16550rb_div.sv =====
// Serial divisor unit: 115200 / baud_rate, one quotient bit per cycle, saturated.
// Depends on u16550rb_pkg.
module u16550rb_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [u16550rb_pkg::BaudWidth-1:0]   divisor,
   output u16550rb_pkg::div_status_type         status
);

   logic [u16550rb_pkg::BaudWidth-1:0] dvs_ff;
   logic [u16550rb_pkg::BaudWidth-1:0] rem_ff;
   logic [u16550rb_pkg::BaudWidth-1:0] rem_in;
   logic [u16550rb_pkg::RefWidth-1:0]  num_ff;
   logic [u16550rb_pkg::RefWidth-1:0]  num_in;
   logic [4:0]                         cnt_ff;
   logic                               busy_ff;
   logic [u16550rb_pkg::DivWidth-1:0]  value_ff;
   logic [u16550rb_pkg::BaudWidth:0]   trial;
   logic [u16550rb_pkg::BaudWidth:0]   diff;
   logic                               q_bit;

   always_comb begin
      trial  = {rem_ff, num_ff[u16550rb_pkg::RefWidth-1]};
      diff   = trial - {1'b0, dvs_ff};
      q_bit  = (trial >= {1'b0, dvs_ff});
      rem_in = q_bit ? diff[u16550rb_pkg::BaudWidth-1:0]
                     : trial[u16550rb_pkg::BaudWidth-1:0];
      num_in = {num_ff[u16550rb_pkg::RefWidth-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
         value_ff <= u16550rb_pkg::DIV_RESET;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'(u16550rb_pkg::RefWidth - 1);
         dvs_ff  <= divisor;
         rem_ff  <= '0;
         num_ff  <= u16550rb_pkg::CLOCK_REF;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         cnt_ff <= cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_ff  <= 1'b0;
            value_ff <= num_in[u16550rb_pkg::RefWidth-1] ? u16550rb_pkg::DIV_SAT
                                                         : num_in[u16550rb_pkg::DivWidth-1:0];
         end
      end
   end

   assign status.busy  = busy_ff;
   assign status.value = value_ff;

endmodule

// ===== hw/rtl/uart_16550_register_bridge_top.sv =====
// Top level of the 16550-style register bridge: register map, line state, result register.
// Depends on u16550rb_pkg and u16550rb_div.
//
// Each request (bus read, bus write, line-state event, break event) yields exactly one response,
// loaded into a response register in the cycle after the request is taken; a new request is
// taken every cycle while the response side keeps up and the divider is idle. After a csr
// write of baud_rate, req_ready stays low while the serial divider produces the divisor latch
// value, one quotient bit a cycle; other csr writes cost nothing. After reset the divisor for
// the reset rate is ready at once.
module uart_16550_register_bridge_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  u16550rb_pkg::req_type               req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output u16550rb_pkg::rsp_type               rsp_payload,
   input  logic                                csr_we,
   input  u16550rb_pkg::csr_index_type         csr_index,
   input  logic [u16550rb_pkg::CsrWidth-1:0]   csr_wdata
);

   logic [4:0] data_bits_ff;
   logic [1:0] stop_code_ff;
   logic [2:0] parity_code_ff;

   logic       dlab_ff, dlab_in;
   logic [7:0] held_rx_ff, held_rx_in;
   logic       cts_bit_ff, cts_bit_in;
   logic       dsr_bit_ff, dsr_bit_in;
   logic       cts_delta_ff, cts_delta_in;
   logic       dsr_delta_ff, dsr_delta_in;
   logic       break_seen_ff, break_seen_in;

   logic                  rsp_valid_ff;
   u16550rb_pkg::rsp_type rsp_ff, rsp_in;

   u16550rb_pkg::div_status_type div_status;
   logic                         accept;
   logic [7:0]                   lcr_value;

   u16550rb_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (csr_we && (csr_index == u16550rb_pkg::CSR_BAUD)),
      .divisor (csr_wdata[u16550rb_pkg::BaudWidth-1:0]),
      .status  (div_status)
   );

   assign req_ready = (!rsp_valid_ff || rsp_ready) && !div_status.busy;
   assign accept    = req_valid && req_ready;

   assign lcr_value = {2'b00, 2'(parity_code_ff[1:0] + 2'd3), (parity_code_ff != 3'd0),
                       (stop_code_ff != 2'd0), 2'(data_bits_ff[1:0] + 2'd3)};

   always_comb begin
      dlab_in       = dlab_ff;
      held_rx_in    = held_rx_ff;
      cts_bit_in    = cts_bit_ff;
      dsr_bit_in    = dsr_bit_ff;
      cts_delta_in  = cts_delta_ff;
      dsr_delta_in  = dsr_delta_ff;
      break_seen_in = break_seen_ff;
      rsp_in        = '0;
      case (req_payload.kind)
         u16550rb_pkg::KIND_READ: begin
            case (req_payload.reg_offset)
               u16550rb_pkg::OFS_DATA: begin
                  if (dlab_ff) begin
                     rsp_in.read_data = div_status.value[7:0];
                  end else if (req_payload.rx_pending) begin
                     held_rx_in        = req_payload.rx_head;
                     rsp_in.rx_consume = 1'b1;
                     rsp_in.read_data  = req_payload.rx_head;
                  end else begin
                     rsp_in.read_data = held_rx_ff;
                  end
               end
               u16550rb_pkg::OFS_DLM: begin
                  if (dlab_ff) begin
                     rsp_in.read_data = div_status.value[15:8];
                  end
               end
               u16550rb_pkg::OFS_LCR: begin
                  rsp_in.read_data = lcr_value;
               end
               u16550rb_pkg::OFS_LSR: begin
                  rsp_in.read_data = {2'b00, req_payload.tx_room, break_seen_ff, 3'b000,
                                      req_payload.rx_pending};
                  break_seen_in    = 1'b0;
               end
               u16550rb_pkg::OFS_MSR: begin
                  rsp_in.read_data = {2'b00, dsr_bit_ff, cts_bit_ff, 2'b00, dsr_delta_ff,
                                      cts_delta_ff};
                  cts_delta_in     = 1'b0;
                  dsr_delta_in     = 1'b0;
               end
               default: begin
                  rsp_in.read_data = 8'd0;
               end
            endcase
         end
         u16550rb_pkg::KIND_WRITE: begin
            if (req_payload.reg_offset == u16550rb_pkg::OFS_DATA) begin
               if (!dlab_ff && req_payload.host_ready && req_payload.tx_room) begin
                  rsp_in.tx_valid = 1'b1;
                  rsp_in.tx_byte  = req_payload.write_data;
               end
            end else if (req_payload.reg_offset == u16550rb_pkg::OFS_LCR) begin
               dlab_in = req_payload.write_data[7];
            end
         end
         u16550rb_pkg::KIND_LINE: begin
            if (cts_bit_ff != req_payload.rts_level) begin
               cts_delta_in = 1'b1;
            end
            if (dsr_bit_ff != req_payload.dtr_level) begin
               dsr_delta_in = 1'b1;
            end
            cts_bit_in = req_payload.rts_level;
            dsr_bit_in = req_payload.dtr_level;
         end
         default: begin
            if (req_payload.break_ms >= u16550rb_pkg::BREAK_MIN_MS) begin
               break_seen_in = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_bits_ff   <= u16550rb_pkg::DATA_RESET;
         stop_code_ff   <= 2'd0;
         parity_code_ff <= 3'd0;
      end else if (csr_we) begin
         case (csr_index)
            u16550rb_pkg::CSR_DATA:   data_bits_ff   <= csr_wdata[4:0];
            u16550rb_pkg::CSR_STOP:   stop_code_ff   <= csr_wdata[1:0];
            u16550rb_pkg::CSR_PARITY: parity_code_ff <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dlab_ff       <= 1'b0;
         held_rx_ff    <= 8'd0;
         cts_bit_ff    <= 1'b0;
         dsr_bit_ff    <= 1'b0;
         cts_delta_ff  <= 1'b0;
         dsr_delta_ff  <= 1'b0;
         break_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (accept) begin
         dlab_ff       <= dlab_in;
         held_rx_ff    <= held_rx_in;
         cts_bit_ff    <= cts_bit_in;
         dsr_bit_ff    <= dsr_bit_in;
         cts_delta_ff  <= cts_delta_in;
         dsr_delta_ff  <= dsr_delta_in;
         break_seen_ff <= break_seen_in;
         rsp_valid_ff  <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_no_accept_while_div_busy: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_ready)
      else $error("request accepted while divisor unit busy");

   a_consume_matches_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rx_consume) |-> (rsp_ff.read_data == held_rx_ff))
      else $error("consumed byte differs from held receive byte");

   a_tx_excludes_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.tx_valid) |-> (!rsp_ff.rx_consume && rsp_ff.read_data == 8'd0))
      else $error("transmit transfer carries read data");

   a_delta_after_change: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.kind == u16550rb_pkg::KIND_LINE
       && req_payload.rts_level != cts_bit_ff) |=> cts_delta_ff)
      else $error("CTS change not flagged");

endmodule

// ===== tb/uart_16550_register_bridge_top_tb.sv =====
// Testbench for uart_16550_register_bridge_top: directed rows, then random phases with idling.
// Checks every response transfer against the fixed value of a directed row or a built-in register model.
// Depends on u16550rb_pkg and the bridge RTL.
module uart_16550_register_bridge_top_tb;

   localparam logic [2:0] OFS_IIR = 3'd2;
   localparam logic [2:0] OFS_MCR = 3'd4;
   localparam logic [2:0] OFS_SCR = 3'd7;

   localparam int unsigned BAUD_REF        = 115200;
   localparam int unsigned BREAK_LIMIT_MS  = 250;
   localparam int unsigned ITEMS_PER_PHASE = 300;
   localparam int unsigned LONG_HOLD       = 200;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned CYCLE_LIMIT     = 400000;

   typedef struct {
      u16550rb_pkg::req_type req;
      bit                    fixed;
      u16550rb_pkg::rsp_type want;
   } row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   u16550rb_pkg::req_type               req_payload = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   u16550rb_pkg::rsp_type               rsp_payload;
   logic                                csr_we = 1'b0;
   u16550rb_pkg::csr_index_type         csr_index = u16550rb_pkg::CSR_BAUD;
   logic [u16550rb_pkg::CsrWidth-1:0]   csr_wdata = '0;

   // register model: configuration and state
   int unsigned cfg_baud      = BAUD_REF;
   int unsigned cfg_data_bits = 8;
   int unsigned cfg_stop      = 0;
   int unsigned cfg_parity    = 0;
   logic        m_dlab        = 1'b0;
   logic [7:0]  m_held_rx     = 8'h00;
   logic        m_cts         = 1'b0;
   logic        m_dsr         = 1'b0;
   logic        m_cts_chg     = 1'b0;
   logic        m_dsr_chg     = 1'b0;
   logic        m_break       = 1'b0;

   u16550rb_pkg::rsp_type pending_results[$];
   row_type               rows[$];
   int unsigned           fail_count    = 0;
   int unsigned           cycle_count   = 0;
   int unsigned           req_idle_pct  = 0;
   int unsigned           rsp_stall_pct = 0;
   int unsigned           hold_asked    = 0;
   int unsigned           hold_served   = 0;
   int unsigned           hold_left     = 0;
   u16550rb_pkg::rsp_type mon_want;

   uart_16550_register_bridge_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [15:0] baud_divisor();
      int unsigned q;
      if (cfg_baud == 0) begin
         return 16'hFFFF;
      end
      q = BAUD_REF / cfg_baud;
      return (q > 32'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic logic [7:0] line_control();
      logic [7:0] v;
      v = 8'((cfg_data_bits + 3) & 3);
      if (cfg_stop != 0) begin
         v |= 8'h04;
      end
      if (cfg_parity != 0) begin
         v |= 8'h08;
      end
      v |= 8'(((cfg_parity + 3) & 3) << 4);
      return v;
   endfunction

   function automatic u16550rb_pkg::rsp_type access_result(input u16550rb_pkg::req_type r);
      u16550rb_pkg::rsp_type o;
      logic [15:0]           dv;
      o  = '0;
      dv = baud_divisor();
      case (r.kind)
         u16550rb_pkg::KIND_READ: begin
            case (r.reg_offset)
               u16550rb_pkg::OFS_DATA: begin
                  if (m_dlab) begin
                     o.read_data = dv[7:0];
                  end else begin
                     if (r.rx_pending) begin
                        m_held_rx    = r.rx_head;
                        o.rx_consume = 1'b1;
                     end
                     o.read_data = m_held_rx;
                  end
               end
               u16550rb_pkg::OFS_DLM: begin
                  if (m_dlab) begin
                     o.read_data = dv[15:8];
                  end
               end
               u16550rb_pkg::OFS_LCR: o.read_data = line_control();
               u16550rb_pkg::OFS_LSR: begin
                  o.read_data = {2'b00, r.tx_room, m_break, 3'b000, r.rx_pending};
                  m_break     = 1'b0;
               end
               u16550rb_pkg::OFS_MSR: begin
                  o.read_data = {2'b00, m_dsr, m_cts, 2'b00, m_dsr_chg, m_cts_chg};
                  m_cts_chg   = 1'b0;
                  m_dsr_chg   = 1'b0;
               end
               default: ;
            endcase
         end
         u16550rb_pkg::KIND_WRITE: begin
            if (r.reg_offset == u16550rb_pkg::OFS_DATA) begin
               if (!m_dlab && r.host_ready && r.tx_room) begin
                  o.tx_valid = 1'b1;
                  o.tx_byte  = r.write_data;
               end
            end else if (r.reg_offset == u16550rb_pkg::OFS_LCR) begin
               m_dlab = r.write_data[7];
            end
         end
         u16550rb_pkg::KIND_LINE: begin
            if (m_cts != r.rts_level) begin
               m_cts_chg = 1'b1;
            end
            if (m_dsr != r.dtr_level) begin
               m_dsr_chg = 1'b1;
            end
            m_cts = r.rts_level;
            m_dsr = r.dtr_level;
         end
         default: begin
            if (r.break_ms >= BREAK_LIMIT_MS) begin
               m_break = 1'b1;
            end
         end
      endcase
      return o;
   endfunction

   // flags: rx_pending, tx_room, host_ready, dtr_level, rts_level
   function automatic u16550rb_pkg::req_type mk(input u16550rb_pkg::kind_type k,
                                                input logic [2:0] ofs,
                                                input logic [7:0] wd, input logic [7:0] head,
                                                input logic [4:0] flags,
                                                input logic [15:0] brk);
      u16550rb_pkg::req_type r;
      r.kind       = k;
      r.reg_offset = ofs;
      r.write_data = wd;
      r.rx_pending = flags[4];
      r.rx_head    = head;
      r.tx_room    = flags[3];
      r.host_ready = flags[2];
      r.dtr_level  = flags[1];
      r.rts_level  = flags[0];
      r.break_ms   = brk;
      return r;
   endfunction

   // want: read_data, {rx_consume, tx_valid}, tx_byte
   function automatic void add_row(input u16550rb_pkg::req_type r, input bit fixed,
                                   input logic [7:0] rd, input logic [1:0] strobes,
                                   input logic [7:0] txb);
      row_type row;
      row.req   = r;
      row.fixed = fixed;
      row.want  = {rd, strobes, txb};
      rows.push_back(row);
   endfunction

   task automatic send(input u16550rb_pkg::req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // baud last: its write starts the divider and holds off requests
   task automatic apply_settings(input int unsigned baud, input int unsigned dbits,
                                 input int unsigned stop, input int unsigned parity);
      csr_we    <= 1'b1;
      csr_index <= u16550rb_pkg::CSR_DATA;
      csr_wdata <= dbits[u16550rb_pkg::CsrWidth-1:0];
      @(posedge clock);
      csr_index <= u16550rb_pkg::CSR_STOP;
      csr_wdata <= stop[u16550rb_pkg::CsrWidth-1:0];
      @(posedge clock);
      csr_index <= u16550rb_pkg::CSR_PARITY;
      csr_wdata <= parity[u16550rb_pkg::CsrWidth-1:0];
      @(posedge clock);
      csr_index <= u16550rb_pkg::CSR_BAUD;
      csr_wdata <= baud[u16550rb_pkg::CsrWidth-1:0];
      @(posedge clock);
      csr_we        <= 1'b0;
      cfg_data_bits  = dbits & 32'h1F;
      cfg_stop       = stop & 32'h3;
      cfg_parity     = parity & 32'h7;
      cfg_baud       = baud & 32'hFFFFFF;
   endtask

   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD;
         rsp_ready   <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected transfer: rd=%h consume=%b tx_valid=%b tx_byte=%h",
                        rsp_payload.read_data, rsp_payload.rx_consume,
                        rsp_payload.tx_valid, rsp_payload.tx_byte);
            end
         end else begin
            mon_want = pending_results.pop_front();
            if (rsp_payload.read_data !== mon_want.read_data ||
                rsp_payload.rx_consume !== mon_want.rx_consume ||
                rsp_payload.tx_valid !== mon_want.tx_valid ||
                rsp_payload.tx_byte !== mon_want.tx_byte) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("mismatch: expected rd=%h consume=%b tx_valid=%b tx_byte=%h",
                           mon_want.read_data, mon_want.rx_consume,
                           mon_want.tx_valid, mon_want.tx_byte);
                  $display("          actual   rd=%h consume=%b tx_valid=%b tx_byte=%h",
                           rsp_payload.read_data, rsp_payload.rx_consume,
                           rsp_payload.tx_valid, rsp_payload.tx_byte);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      u16550rb_pkg::req_type r;
      u16550rb_pkg::rsp_type want;
      int unsigned           baud;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_DATA, 8'hFF, 8'hC3, 5'b01111,
                 16'hFFFF), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_LSR, 8'h00, 8'h00, 5'b11000,
                 16'h0000), 1, 8'h21, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_LCR, 8'h00, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h33, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_DATA, 8'h00, 8'hFF, 5'b10000,
                 16'h0000), 1, 8'hFF, 2'b10, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_DLM, 8'hFF, 8'hAA, 5'b11111,
                 16'hFFFF), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, OFS_IIR, 8'hFF, 8'hAA, 5'b11111,
                 16'hFFFF), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, OFS_MCR, 8'hFF, 8'hAA, 5'b11111,
                 16'hFFFF), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, OFS_SCR, 8'hFF, 8'hAA, 5'b11111,
                 16'hFFFF), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_WRITE, u16550rb_pkg::OFS_DATA, 8'hA5, 8'h00, 5'b01100,
                 16'h0000), 1, 8'h00, 2'b01, 8'hA5);
      add_row(mk(u16550rb_pkg::KIND_WRITE, u16550rb_pkg::OFS_DATA, 8'hFF, 8'h00, 5'b01000,
                 16'h0000), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_WRITE, u16550rb_pkg::OFS_DATA, 8'h3C, 8'h00, 5'b00100,
                 16'h0000), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_WRITE, OFS_SCR, 8'h80, 8'hFF, 5'b11111,
                 16'hFFFF), 0, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_WRITE, u16550rb_pkg::OFS_LCR, 8'h80, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_DATA, 8'h00, 8'h5A, 5'b10000,
                 16'h0000), 1, 8'h01, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_DLM, 8'h00, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_WRITE, u16550rb_pkg::OFS_DATA, 8'h55, 8'h00, 5'b01100,
                 16'h0000), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_WRITE, u16550rb_pkg::OFS_LCR, 8'h7F, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_DATA, 8'h00, 8'h00, 5'b00000,
                 16'h0000), 1, 8'hFF, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_LINE, u16550rb_pkg::OFS_LSR, 8'hFF, 8'hFF, 5'b00011,
                 16'hFFFF), 0, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_MSR, 8'h00, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h33, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_LINE, u16550rb_pkg::OFS_DATA, 8'h00, 8'h00, 5'b00010,
                 16'h0000), 0, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_MSR, 8'h00, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h21, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_BREAK, u16550rb_pkg::OFS_DATA, 8'hFF, 8'hFF, 5'b11111,
                 16'd249), 0, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_LSR, 8'h00, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_BREAK, u16550rb_pkg::OFS_DATA, 8'h00, 8'h00, 5'b00000,
                 16'd250), 0, 8'h00, 2'b00, 8'h00);
      add_row(mk(u16550rb_pkg::KIND_READ, u16550rb_pkg::OFS_LSR, 8'h00, 8'h00, 5'b00000,
                 16'h0000), 1, 8'h10, 2'b00, 8'h00);

      foreach (rows[i]) begin
         send(rows[i].req);
         want = access_result(rows[i].req);
         if (rows[i].fixed) begin
            want = rows[i].want;
         end
         pending_results.push_back(want);
      end
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         baud = $urandom_range(1) ? $urandom_range(1, 3000) : $urandom_range(1, 24'hFFFFFF);
         case (phase)
            0: begin
               apply_settings(BAUD_REF, 8, 0, 0);
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               apply_settings(1, 5, 2, 4);
               req_idle_pct  = 63;
               rsp_stall_pct = 0;
            end
            2: begin
               apply_settings(24'hFFFFFF, 16, 1, 1);
               req_idle_pct  = 0;
               rsp_stall_pct = 63;
            end
            3: begin
               apply_settings(0, 7, 0, 3);
               req_idle_pct  = 22;
               rsp_stall_pct = 22;
            end
            4: begin
               apply_settings(baud, $urandom_range(5, 16), $urandom_range(2),
                              $urandom_range(4));
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
               hold_asked++;
            end
            default: begin
               apply_settings(baud, $urandom_range(5, 16), $urandom_range(2),
                              $urandom_range(4));
               req_idle_pct  = 22;
               rsp_stall_pct = 22;
            end
         endcase

         repeat (ITEMS_PER_PHASE) begin
            r.kind       = u16550rb_pkg::kind_type'(2'($urandom_range(3)));
            r.reg_offset = 3'($urandom_range(7));
            r.write_data = 8'($urandom);
            r.rx_pending = 1'($urandom_range(1));
            r.rx_head    = 8'($urandom);
            r.tx_room    = 1'($urandom_range(1));
            r.host_ready = ($urandom_range(3) != 0);
            r.dtr_level  = 1'($urandom_range(1));
            r.rts_level  = 1'($urandom_range(1));
            case ($urandom_range(3))
               0:       r.break_ms = 16'($urandom_range(0, 65535));
               1:       r.break_ms = 16'($urandom_range(240, 260));
               2:       r.break_ms = $urandom_range(1) ? 16'hFFFF : 16'h0000;
               default: r.break_ms = 16'($urandom_range(0, 600));
            endcase
            send(r);
            pending_results.push_back(access_result(r));
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
